/* rtl/core/lps_pkg.sv */
`default_nettype none

package lps_pkg;

  localparam int COLOR_BITS  = 32;
  localparam int FRAME_BITS  = 15;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(640);
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(480);

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_width;
    logic [FRAME_BITS-1:0] frame_height;
  } frame_t;

endpackage

`default_nettype wire

/* rtl/core/lps_cmd_if.sv */
`default_nettype none

interface lps_cmd_if #(
  parameter int COORD_BITS = 16
) ();
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [COORD_BITS-1:0]        x_start;
  logic signed [COORD_BITS-1:0]        y_start;
  logic signed [COORD_BITS-1:0]        x_end;
  logic signed [COORD_BITS-1:0]        y_end;
  logic [lps_pkg::COLOR_BITS-1:0]      line_color;

  modport source (
    output valid, command, x_start, y_start, x_end, y_end, line_color,
    input  ready
  );
  modport sink (
    input  valid, command, x_start, y_start, x_end, y_end, line_color,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/lps_pix_if.sv */
`default_nettype none

interface lps_pix_if #(
  parameter int COORD_BITS = 16
) ();
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        pixel_x;
  logic signed [COORD_BITS-1:0]        pixel_y;
  logic [lps_pkg::COLOR_BITS-1:0]      pixel_color;
  logic                                inside_res;
  logic                                last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, inside_res, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, inside_res, last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/line_pixel_stepper.sv */
// Path: an accepted step request is written into the request queue, and its pixel is loaded into the output
//   register when the back pops it; a stalled pixel output can hold that pop off.
// Throughput: one request per clock, loads and steps alike, while the pixel output is not stalled;
//   the back's decision-term add and the two-entry request queue set that rate.
// Reset: synchronous, active high; clears the queue, the line-active flag and the output
//   valid, and sets frame width 640 and frame height 480.
`default_nettype none

module line_pixel_stepper #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  lps_cmd_if.sink                             cmd,
  lps_pix_if.source                           pix,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lps_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [lps_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lps_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);

  // One queued request: the command kind plus the line setup worked out by the
  // front. Setup fields mean nothing for a step request.
  typedef struct packed {
    logic                            is_step;
    logic                            major_is_x;
    logic                            minor_neg;
    logic signed [COORD_BITS-1:0]    start_x;
    logic signed [COORD_BITS-1:0]    start_y;
    logic signed [COORD_BITS-1:0]    major_stop;
    logic [COORD_BITS:0]             minor_delta;
    logic [COORD_BITS:0]             major_delta;
    logic [lps_pkg::COLOR_BITS-1:0]  color;
  } entry_t;

  lps_pkg::frame_t frame;

  logic   q_push;
  logic   q_ready;
  entry_t q_in;
  logic   q_valid;
  entry_t q_out;
  logic   q_pop;

  // Frame size registers behind the APB port.
  lps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .frame   (frame)
  );

  // Front: take a request, classify it, and for a load pick the major axis,
  // order the endpoints and take the absolute deltas.
  lps_front #(
    .COORD_BITS (COORD_BITS),
    .entry_t    (entry_t)
  ) u_front (
    .cmd     (cmd),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  // Short queue so the front keeps accepting while the output stalls.
  lps_queue #(
    .entry_t (entry_t)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_out),
    .pop        (q_pop)
  );

  // Back: hold the line state, emit one pixel per step, advance the
  // decision term, and drop steps that arrive with no line in progress.
  lps_back #(
    .COORD_BITS (COORD_BITS),
    .entry_t    (entry_t)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .pix     (pix)
  );

endmodule

`default_nettype wire

/* rtl/core/lps_cfg.sv */
`default_nettype none

module lps_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lps_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [lps_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lps_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output lps_pkg::frame_t                     frame
);

  lps_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign reg_idx = lps_pkg::reg_idx_t'(paddr[lps_pkg::APB_ADDR_BITS-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.frame_width  <= lps_pkg::FRAME_WIDTH_RESET;
      frame.frame_height <= lps_pkg::FRAME_HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        lps_pkg::REG_FRAME_WIDTH:  frame.frame_width  <= pwdata[lps_pkg::FRAME_BITS-1:0];
        lps_pkg::REG_FRAME_HEIGHT: frame.frame_height <= pwdata[lps_pkg::FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lps_pkg::REG_FRAME_WIDTH:  prdata = lps_pkg::APB_DATA_BITS'(frame.frame_width);
      lps_pkg::REG_FRAME_HEIGHT: prdata = lps_pkg::APB_DATA_BITS'(frame.frame_height);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/lps_front.sv */
`default_nettype none

module lps_front #(
  parameter int  COORD_BITS = 16,
  parameter type entry_t    = logic
) (
  lps_cmd_if.sink  cmd,
  input  logic     q_ready,
  output logic     q_push,
  output entry_t   q_data
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] minor_raw;
  logic [DW-1:0]        adx;
  logic [DW-1:0]        ady;
  logic                 major_is_x;
  logic                 swap;

  assign cmd.ready = q_ready;
  assign q_push    = cmd.valid && q_ready;

  always_comb begin
    dx = {cmd.x_end[COORD_BITS-1], cmd.x_end} - {cmd.x_start[COORD_BITS-1], cmd.x_start};
    dy = {cmd.y_end[COORD_BITS-1], cmd.y_end} - {cmd.y_start[COORD_BITS-1], cmd.y_start};
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);

    // Ties go to y-major.
    major_is_x = ady < adx;
    // Swap endpoints so the major coordinate rises.
    swap       = major_is_x ? dx[DW-1] : dy[DW-1];
    minor_raw  = major_is_x ? dy : dx;

    q_data.is_step    = (cmd.command == lps_pkg::CMD_STEP);
    q_data.major_is_x = major_is_x;
    q_data.minor_neg  = swap ? (!minor_raw[DW-1] && (minor_raw != '0)) : minor_raw[DW-1];
    q_data.start_x    = swap ? cmd.x_end : cmd.x_start;
    q_data.start_y    = swap ? cmd.y_end : cmd.y_start;
    if (major_is_x) begin
      q_data.major_stop = swap ? cmd.x_start : cmd.x_end;
    end else begin
      q_data.major_stop = swap ? cmd.y_start : cmd.y_end;
    end
    q_data.minor_delta = major_is_x ? ady : adx;
    q_data.major_delta = major_is_x ? adx : ady;
    q_data.color       = cmd.line_color;
  end

endmodule

`default_nettype wire

/* rtl/core/lps_queue.sv */
`default_nettype none

module lps_queue #(
  parameter type entry_t = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   push_ready,
  output logic   pop_valid,
  output entry_t pop_data,
  input  logic   pop
);

  entry_t                        slots [lps_pkg::QUEUE_DEPTH];
  logic [lps_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [lps_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [lps_pkg::QCNT_BITS-1:0] count;

  assign push_ready = count != lps_pkg::QCNT_BITS'(lps_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lps_pkg::QPTR_BITS'(lps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lps_pkg::QPTR_BITS'(lps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lps_back.sv */
`default_nettype none

module lps_back #(
  parameter int  COORD_BITS = 16,
  parameter type entry_t    = logic
) (
  input  logic              clk,
  input  logic              rst,
  input  lps_pkg::frame_t   frame,
  input  logic              q_valid,
  input  entry_t            q_data,
  output logic              q_pop,
  lps_pix_if.source         pix
);

  localparam int DW  = COORD_BITS + 1;
  localparam int DTW = COORD_BITS + 4;
  localparam int CW  = (COORD_BITS > lps_pkg::FRAME_BITS) ? COORD_BITS : lps_pkg::FRAME_BITS;

  logic                            active;
  logic                            major_is_x;
  logic                            minor_neg;
  logic signed [COORD_BITS-1:0]    cur_x;
  logic signed [COORD_BITS-1:0]    cur_y;
  logic signed [COORD_BITS-1:0]    major_stop;
  logic signed [DTW-1:0]           decision;
  logic signed [DTW-1:0]           inc_axis;
  logic signed [DTW-1:0]           inc_diag;
  logic [lps_pkg::COLOR_BITS-1:0]  held_color;

  logic                            out_valid;
  logic signed [COORD_BITS-1:0]    out_x;
  logic signed [COORD_BITS-1:0]    out_y;
  logic [lps_pkg::COLOR_BITS-1:0]  out_color;
  logic                            out_in_frame;
  logic                            out_last;

  logic                            out_free;
  logic                            do_load;
  logic                            do_step;
  logic signed [COORD_BITS-1:0]    major_now;
  logic signed [COORD_BITS-1:0]    minor_now;
  logic signed [COORD_BITS-1:0]    major_next;
  logic signed [COORD_BITS-1:0]    minor_moved;
  logic                            is_last;
  logic                            in_frame;
  logic                            dt_pos;
  logic signed [DTW-1:0]           minor2;
  logic signed [DTW-1:0]           major1;
  logic signed [DTW-1:0]           major2;

  always_comb begin
    out_free = !out_valid || pix.ready;
    // Loads and idle steps drain freely; a live step needs the output slot.
    q_pop    = q_valid && (!q_data.is_step || !active || out_free);
    do_load  = q_pop && !q_data.is_step;
    do_step  = q_pop && q_data.is_step && active;

    major_now   = major_is_x ? cur_x : cur_y;
    minor_now   = major_is_x ? cur_y : cur_x;
    major_next  = major_now + 1'b1;
    minor_moved = minor_neg ? minor_now - 1'b1 : minor_now + 1'b1;
    is_last     = major_now >= major_stop;
    in_frame    = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] &&
                  (CW'($unsigned(cur_x)) < CW'(frame.frame_width)) &&
                  (CW'($unsigned(cur_y)) < CW'(frame.frame_height));
    dt_pos      = !decision[DTW-1] && (decision != '0);

    minor2 = {{(DTW-DW-1){1'b0}}, q_data.minor_delta, 1'b0};
    major1 = {{(DTW-DW){1'b0}},   q_data.major_delta};
    major2 = {{(DTW-DW-1){1'b0}}, q_data.major_delta, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_load) begin
        active <= 1'b1;
      end else if (do_step && is_last) begin
        active <= 1'b0;
      end
      if (do_step) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      major_is_x <= q_data.major_is_x;
      minor_neg  <= q_data.minor_neg;
      cur_x      <= q_data.start_x;
      cur_y      <= q_data.start_y;
      major_stop <= q_data.major_stop;
      decision   <= minor2 - major1;
      inc_axis   <= minor2;
      inc_diag   <= minor2 - major2;
      held_color <= q_data.color;
    end else if (do_step && !is_last) begin
      if (major_is_x) begin
        cur_x <= major_next;
        if (dt_pos) begin
          cur_y <= minor_moved;
        end
      end else begin
        cur_y <= major_next;
        if (dt_pos) begin
          cur_x <= minor_moved;
        end
      end
      decision <= decision + (dt_pos ? inc_diag : inc_axis);
    end
    if (do_step) begin
      out_x        <= cur_x;
      out_y        <= cur_y;
      out_color    <= held_color;
      out_in_frame <= in_frame;
      out_last     <= is_last;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_x     = out_x;
  assign pix.pixel_y     = out_y;
  assign pix.pixel_color = out_color;
  assign pix.inside_res  = out_in_frame;
  assign pix.last        = out_last;

endmodule

`default_nettype wire

/* rtl/core/lps_checker.sv */
`default_nettype none

module lps_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_ready,
  input logic                               pix_valid,
  input logic                               pix_ready,
  input logic signed [COORD_BITS-1:0]       pixel_x,
  input logic signed [COORD_BITS-1:0]       pixel_y,
  input logic [lps_pkg::COLOR_BITS-1:0]     pixel_color,
  input logic                               inside_res,
  input logic                               last
);

  // A stalled pixel holds.
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pixel_x) && $stable(pixel_y) &&
      $stable(pixel_color) && $stable(inside_res) && $stable(last))
    else $error("stalled pixel changed");

  // Reset empties the queue and the output register.
  a_reset_ready: assert property (@(posedge clk) rst |=> cmd_ready)
    else $error("request port not ready after reset");

  a_reset_no_pix: assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("pixel shown after reset");

  // The queue only fills through an accepted request.
  a_full_after_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(cmd_ready) |-> $past(cmd_valid && cmd_ready))
    else $error("queue filled with no request accepted");

  // An inside pixel has non-negative coordinates.
  a_inside_nonneg: assert property (@(posedge clk) disable iff (rst)
    pix_valid && inside_res |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
    else $error("inside flag on negative coordinate");

endmodule

bind line_pixel_stepper lps_checker #(
  .COORD_BITS (COORD_BITS)
) u_lps_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .pix_valid   (pix.valid),
  .pix_ready   (pix.ready),
  .pixel_x     (pix.pixel_x),
  .pixel_y     (pix.pixel_y),
  .pixel_color (pix.pixel_color),
  .inside_res  (pix.inside_res),
  .last        (pix.last)
);

`default_nettype wire
